@@ design/ksc_pkg.sv @@
// Shared types, constants and helpers for the keyword shift cipher.
package ksc_pkg;

  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [LETTER_W:0]   wide_t;
  typedef logic [7:0]          byte_t;

  localparam letter_t LETTERS_L    = letter_t'(LETTERS);
  localparam wide_t   LETTERS_WIDE = wide_t'(LETTERS);
  localparam letter_t SHIFT_RESET  = 5'd1;
  localparam byte_t   LOWER_A      = 8'd97;
  localparam byte_t   LOWER_Z      = 8'd122;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } op_t;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_SHIFT     = 1'b1;

  typedef struct packed {
    logic    clear;
    logic    append;
    letter_t letter;
  } key_cmd_t;

  function automatic logic is_lower(input byte_t b);
    return (b >= LOWER_A) && (b <= LOWER_Z);
  endfunction

endpackage

@@ design/ksc_alphabet.sv @@
// Keyed alphabet state (alphabet and its inverse) with incremental update and lookup.
module ksc_alphabet (
  input  logic               clk,
  input  logic               rst,
  input  ksc_pkg::key_cmd_t  cmd,
  input  ksc_pkg::letter_t   text_letter,
  input  logic               direction,
  input  ksc_pkg::letter_t   shift,
  output ksc_pkg::letter_t   mapped
);
  import ksc_pkg::*;

  // keyed[p]: letter at position p; pos[y]: position of letter y
  letter_t keyed      [LETTERS];
  letter_t keyed_next [LETTERS];
  letter_t pos        [LETTERS];
  letter_t pos_next   [LETTERS];
  letter_t key_length, key_length_next;
  logic [LETTERS-1:0] mask, mask_next;
  logic do_append;
  letter_t x_pos;

  letter_t s_mod;
  wide_t   enc_sum, enc_red;
  wide_t   dec_sum, dec_red;

  always_comb begin
    x_pos     = pos[cmd.letter];
    do_append = cmd.append && !mask[cmd.letter] && (key_length < LETTERS_L);
    keyed_next      = keyed;
    pos_next        = pos;
    key_length_next = key_length;
    mask_next       = mask;
    if (cmd.clear) begin
      for (int i = 0; i < LETTERS; i++) begin
        keyed_next[i] = letter_t'(i);
        pos_next[i]   = letter_t'(i);
      end
      key_length_next = '0;
      mask_next       = '0;
    end else if (do_append) begin
      // new letter lands at the end of the key; unused letters ahead of it slide right
      for (int p = 0; p < LETTERS; p++) begin
        if (letter_t'(p) == key_length) begin
          keyed_next[p] = cmd.letter;
        end else if ((letter_t'(p) > key_length) && (letter_t'(p) <= x_pos)) begin
          keyed_next[p] = keyed[(p + LETTERS - 1) % LETTERS];
        end
      end
      for (int y = 0; y < LETTERS; y++) begin
        if (letter_t'(y) == cmd.letter) begin
          pos_next[y] = key_length;
        end else if ((pos[y] >= key_length) && (pos[y] < x_pos)) begin
          pos_next[y] = pos[y] + 5'd1;
        end
      end
      key_length_next = key_length + 5'd1;
      mask_next       = mask | (LETTERS'(1) << cmd.letter);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LETTERS; i++) begin
        keyed[i] <= letter_t'(i);
        pos[i]   <= letter_t'(i);
      end
      key_length <= '0;
      mask       <= '0;
    end else begin
      keyed      <= keyed_next;
      pos        <= pos_next;
      key_length <= key_length_next;
      mask       <= mask_next;
    end
  end

  // shift is taken mod 26; 5-bit value never reaches 52
  always_comb begin
    s_mod   = (shift >= LETTERS_L) ? (shift - LETTERS_L) : shift;
    enc_sum = {1'b0, text_letter} + LETTERS_WIDE - {1'b0, s_mod};
    enc_red = (enc_sum >= LETTERS_WIDE) ? (enc_sum - LETTERS_WIDE) : enc_sum;
    dec_sum = {1'b0, pos[text_letter]} + {1'b0, s_mod};
    dec_red = (dec_sum >= LETTERS_WIDE) ? (dec_sum - LETTERS_WIDE) : dec_sum;
    mapped  = direction ? dec_red[LETTER_W-1:0] : keyed[enc_red[LETTER_W-1:0]];
  end

  a_len_matches_mask: assert property (@(posedge clk) disable iff (rst)
    key_length == letter_t'($countones(mask)))
    else $error("key length disagrees with used-letter mask");

  a_inverse_head: assert property (@(posedge clk) disable iff (rst)
    pos[keyed[0]] == 5'd0)
    else $error("alphabet and inverse out of step");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    key_length <= LETTERS_L)
    else $error("key length above alphabet size");

endmodule

@@ design/keyword_shift_cipher.sv @@
// Top level of the keyword shift cipher: request pipeline, config registers, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries requests of op + data_byte:
//     OP_CLEAR empties the key, OP_APPEND adds a lowercase key letter (others and
//     repeats are dropped), OP_TEXT substitutes one byte. Only OP_TEXT makes a
//     result; op 3 is dropped silently.
//   Output channel (out_valid / out_stall) carries out_byte, one per OP_TEXT.
//   Config port: cfg_write with cfg_index 0 sets direction (cfg_data[0]; 0 encrypt,
//     1 decrypt), index 1 sets shift (cfg_data, 26 or 0 = no rotation). Write only
//     while no request is in flight.
// Timing:
//   One request per cycle sustained while out_stall holds no result. A request is registered
//   at accept, looked up against the keyed alphabet in the following cycle, and
//   written to the output register, raising out_valid, once it can take a value. Key updates
//   are incremental on a 26-entry alphabet and inverse, so a text lookup is one mux.
// Reset (rst, synchronous): key cleared, direction 0, shift 1, both channels empty.
// Stall: while out_stall holds a result, the request stage holds too and in_stall
//   rises only once that stage is occupied, so one request can still be taken.
module keyword_shift_cipher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  ksc_pkg::byte_t        data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ksc_pkg::byte_t        out_byte,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  ksc_pkg::letter_t      cfg_data
);
  import ksc_pkg::*;

  // config registers
  logic    direction;
  letter_t shift;

  // request stage
  logic        s1_valid;
  logic [1:0]  s1_op;
  byte_t       s1_byte;

  logic     advance;   // result register can take a new value
  logic     fire;      // request stage is consumed this cycle
  logic     text_fire;
  logic     s1_lower;
  byte_t    s1_diff;
  key_cmd_t cmd;
  letter_t  mapped;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;
  assign s1_lower = is_lower(s1_byte);
  assign s1_diff  = s1_byte - LOWER_A;

  // op decode
  always_comb begin
    cmd.clear  = 1'b0;
    cmd.append = 1'b0;
    cmd.letter = s1_diff[LETTER_W-1:0];
    text_fire  = 1'b0;
    case (op_t'(s1_op))
      OP_CLEAR:  cmd.clear  = fire;
      OP_APPEND: cmd.append = fire && s1_lower;
      OP_TEXT:   text_fire  = fire;
      default:   ;  // unused op: dropped
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= op;
      s1_byte <= data_byte;
    end
  end

  ksc_alphabet u_alphabet (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .text_letter (s1_diff[LETTER_W-1:0]),
    .direction   (direction),
    .shift       (shift),
    .mapped      (mapped)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= text_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (text_fire) begin
      out_byte <= s1_lower ? (LOWER_A + {3'b000, mapped}) : s1_byte;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      shift     <= SHIFT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_SHIFT:     shift     <= cfg_data;
        default:       ;
      endcase
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_text_result: assert property (@(posedge clk) disable iff (rst)
    text_fire |=> out_valid)
    else $error("text request lost its result");

  a_letter_stays_letter: assert property (@(posedge clk) disable iff (rst)
    (text_fire && s1_lower) |=> ((out_byte >= LOWER_A) && (out_byte <= LOWER_Z)))
    else $error("lowercase input gave non-lowercase result");

endmodule

@@ bench/keyword_shift_cipher_tb.sv @@
// Self-checking testbench for the keyword shift cipher: directed, config sweep, backpressure, sender pause, random.
`timescale 1ns / 100ps

module keyword_shift_cipher_tb;
  import ksc_pkg::*;

  // op 3 has no name in the package; the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles a request may still be in flight after the last result
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 2000;
  localparam int RANDOM_TARGET = 1400;

  typedef struct {
    byte_t text_in;
    byte_t cipher_out;
  } text_expect_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  logic [1:0]     op;
  byte_t          data_byte;
  logic           out_valid;
  logic           out_stall;
  byte_t          out_byte;
  logic           cfg_write;
  logic           cfg_index;
  letter_t        cfg_data;

  // predictor state: key sequence, letter mask and the two registers
  letter_t        key_seq [LETTERS];
  int             key_len;
  logic [25:0]    key_mask;
  logic           decrypt;
  letter_t        cipher_shift;

  // expected substitutions, oldest first
  text_expect_t   pending_text [$];

  // pacing controls shared between the stimulus and the result side
  bit             sender_idle;
  bit             sink_idle;
  int             hold_left;

  int             error_count;
  int             items_sent;
  int             results_seen;
  int             cfg_writes;
  int             stalled_cycles;

  keyword_shift_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: far beyond the slowest legal run (every item with a full gap,
  // every result with a full stall, plus the long hold-off).
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Expected output for one text byte under the current key and registers.
  // Keyed alphabet = key letters in order, then unused letters a..z; it is
  // rotated right by shift mod 26, then indexed (encrypt) or searched (decrypt).
  function automatic byte_t cipher_byte(input byte_t text);
    letter_t keyed [LETTERS];
    letter_t rotated [LETTERS];
    int      n;
    int      rot;
    letter_t idx;
    byte_t   result;
    result = text;
    if (text >= LOWER_A && text <= LOWER_Z) begin
      n = 0;
      for (int i = 0; i < key_len; i++) begin
        keyed[n] = key_seq[i];
        n++;
      end
      for (int i = 0; i < LETTERS; i++) begin
        if (!key_mask[i]) begin
          keyed[n] = letter_t'(i);
          n++;
        end
      end
      rot = int'(cipher_shift) % LETTERS;
      for (int i = 0; i < LETTERS; i++) begin
        rotated[i] = keyed[(i + LETTERS - rot) % LETTERS];
      end
      idx = letter_t'(text - LOWER_A);
      if (!decrypt) begin
        result = LOWER_A + byte_t'(rotated[idx]);
      end else begin
        for (int j = 0; j < LETTERS; j++) begin
          if (rotated[j] == idx) result = LOWER_A + byte_t'(j);
        end
      end
    end
    return result;
  endfunction

  // Update the key state for one accepted request, queue the result if any.
  task automatic track_request(input logic [1:0] req_op, input byte_t req_byte);
    letter_t      idx;
    text_expect_t entry;
    idx = letter_t'(req_byte - LOWER_A);
    case (req_op)
      OP_CLEAR: begin
        key_len = 0;
        key_mask = '0;
      end
      OP_APPEND: begin
        // non-letters and repeats are dropped
        if (req_byte >= LOWER_A && req_byte <= LOWER_Z && !key_mask[idx] &&
            key_len < LETTERS) begin
          key_seq[key_len] = idx;
          key_len++;
          key_mask[idx] = 1'b1;
        end
      end
      OP_TEXT: begin
        entry.text_in = req_byte;
        entry.cipher_out = cipher_byte(req_byte);
        pending_text.push_back(entry);
      end
      default: ;
    endcase
  endtask

  // Offer one request and hold it until accepted. Entered at a clock edge.
  // A gap only lowers valid; with no gap valid stays high into the next request.
  task automatic send_request(input logic [1:0] req_op, input byte_t req_byte);
    int gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    data_byte <= req_byte;
    do begin
      @(posedge clk);
      if (in_stall) stalled_cycles++;
    end while (in_stall);
    track_request(req_op, req_byte);
    items_sent++;
  endtask

  // Stop offering, let every expected result arrive, then let trailing
  // key requests (which give no result) finish inside the block.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes direction then shift on back-to-back edges, block idle.
  task automatic set_config(input logic dir, input letter_t shift_val);
    logic [3:0] junk;
    settle_block();
    junk = 4'($urandom_range(0, 15));
    cfg_write <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_data <= {junk, dir};
    @(posedge clk);
    cfg_index <= CFG_SHIFT;
    cfg_data <= shift_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    decrypt = dir;
    cipher_shift = shift_val;
    cfg_writes += 2;
  endtask

  function automatic letter_t random_shift();
    letter_t picks [6] = '{5'd0, 5'd1, 5'd25, 5'd26, 5'd27, 5'd31};
    if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 5)];
    return letter_t'($urandom_range(0, 31));
  endfunction

  function automatic byte_t random_text();
    if ($urandom_range(0, 7) == 0) return byte_t'($urandom_range(0, 255));
    return LOWER_A + byte_t'($urandom_range(0, 25));
  endfunction

  // Appends count key letters: a shuffled alphabet when distinct, else random
  // letters with repeats and the odd non-letter byte.
  task automatic load_key(input int count, input bit distinct);
    byte_t letters [LETTERS];
    byte_t tmp;
    byte_t b;
    int    k;
    for (int i = 0; i < LETTERS; i++) letters[i] = LOWER_A + byte_t'(i);
    for (int i = LETTERS - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = letters[i];
      letters[i] = letters[k];
      letters[k] = tmp;
    end
    for (int i = 0; i < count; i++) begin
      if (distinct) begin
        b = letters[i % LETTERS];
      end else if ($urandom_range(0, 7) == 0) begin
        b = byte_t'($urandom_range(0, 255));
      end else begin
        b = LOWER_A + byte_t'($urandom_range(0, 25));
      end
      send_request(OP_APPEND, b);
    end
  endtask

  // Reset config (encrypt, shift 1), empty key: byte extremes, the letter
  // boundaries, key letter edge cases, the unused op.
  task automatic test_directed();
    byte_t edge_bytes [8] = '{8'h61, 8'h7a, 8'h00, 8'hff, 8'h60, 8'h7b, 8'h41, 8'h5a};
    foreach (edge_bytes[i]) send_request(OP_TEXT, edge_bytes[i]);
    send_request(OP_UNUSED, 8'h61);
    send_request(OP_APPEND, 8'h7a);
    send_request(OP_APPEND, 8'h71);
    send_request(OP_APPEND, 8'h7a);  // repeated letter
    send_request(OP_APPEND, 8'h40);  // not a lowercase letter
    send_request(OP_APPEND, 8'hff);
    send_request(OP_TEXT, 8'h61);
    send_request(OP_TEXT, 8'h71);
    send_request(OP_TEXT, 8'h7a);
    send_request(OP_CLEAR, 8'h7a);
    send_request(OP_TEXT, 8'h6d);
    settle_block();
  endtask

  // Each direction against the shift extremes, one run with a full 26-letter key.
  task automatic test_config_sweep();
    logic    dirs [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    letter_t shifts [6] = '{5'd31, 5'd26, 5'd0, 5'd27, 5'd1, 5'd13};
    for (int s = 0; s < 6; s++) begin
      set_config(dirs[s], shifts[s]);
      send_request(OP_CLEAR, byte_t'($urandom_range(0, 255)));
      load_key(s == 0 ? LETTERS + 2 : $urandom_range(0, 12), s != 3);
      for (int i = 0; i < LETTERS; i++) send_request(OP_TEXT, LOWER_A + byte_t'(i));
      send_request(OP_TEXT, byte_t'($urandom_range(0, 255)));
    end
    settle_block();
  endtask

  // Receiver holds off long while the sender streams back to back, so the
  // block fills and in_stall must rise.
  task automatic test_backpressure();
    set_config(1'($urandom_range(0, 1)), random_shift());
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    send_request(OP_CLEAR, 8'h00);
    load_key(6, 1'b1);
    hold_left = 80;
    repeat (40) send_request(OP_TEXT, random_text());
    settle_block();
  endtask

  // Sender pauses mid-stream until the block is fully drained, then resumes.
  task automatic test_sender_pause();
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (20) send_request(OP_TEXT, random_text());
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (20) send_request(OP_TEXT, random_text());
    settle_block();
  endtask

  // Phases of mostly well-formed traffic (clear, key, text) with random
  // pacing and occasional config changes; some phases are raw noise.
  task automatic test_random_traffic();
    int kind;
    while (items_sent < RANDOM_TARGET) begin
      sender_idle = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 3) == 0) begin
        set_config(1'($urandom_range(0, 1)), random_shift());
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_request(OP_CLEAR, byte_t'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) load_key(LETTERS + $urandom_range(0, 3), 1'b1);
        else load_key($urandom_range(0, 8), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(8, 30)) send_request(OP_TEXT, random_text());
      end else begin
        repeat (20) begin
          send_request(2'($urandom_range(0, 3)),
                       $urandom_range(0, 1) ? random_text() : byte_t'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then draw the stall for the next one. A hold-off request overrides.
  initial begin : result_checker
    int           stall_left;
    text_expect_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (pending_text.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", out_byte));
        end else begin
          want = pending_text.pop_front();
          if (out_byte !== want.cipher_out) begin
            report_mismatch($sformatf("text %h: out_byte %h, expected %h",
                                      want.text_in, out_byte, want.cipher_out));
          end
        end
        stall_left = sink_idle ? $urandom_range(0, 7) : 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int waited;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_CLEAR;
    data_byte <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_DIRECTION;
    cfg_data <= '0;
    // predictor matches the block's reset values
    key_len = 0;
    key_mask = '0;
    decrypt = 1'b0;
    cipher_shift = SHIFT_RESET;
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    hold_left = 0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    stalled_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    // drain: bounded wait for outstanding results, then the tail latency
    in_valid <= 1'b0;
    waited = 0;
    while (pending_text.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (pending_text.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_text.size()));
    end

    $display("Sent %0d requests (clear, append, text, unused op) over %0d register writes;",
             items_sent, cfg_writes);
    $display("checked %0d substituted bytes, input side stalled %0d cycles.",
             results_seen, stalled_cycles);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
